/* rtl/core/bilinear_integer_zoom_core_macros.svh */
// assertion macros for the bilinear integer zoom core
// used by the top level only, no other dependencies
`ifndef BILINEAR_INTEGER_ZOOM_CORE_MACROS_SVH
`define BILINEAR_INTEGER_ZOOM_CORE_MACROS_SVH

// same-cycle implication under reset
`define BZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define BZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bzoom_pkg.sv */
// types, register indexes and reciprocal table for the bilinear zoom core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bzoom_pkg;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int COORD_W    = 13;
    localparam int ROW_CNT_W  = 10;
    localparam int HEIGHT_LIMIT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [12:0] out_row;
        logic [12:0] out_col;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        tile_last;
        logic        frame_last;
    } t_pix_out;

    // controller to datapath
    typedef struct packed {
        logic        load;
        logic        issue;
        logic [3:0]  kr;
        logic [3:0]  kc;
        logic [12:0] row;
        logic [12:0] col;
        logic        tile_last;
        logic        frame_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic advance;
    } t_dp_stat;

    // ceil(2^16 / f), exact floor division for dividends below 2^11
    function automatic logic [16:0] recip(input logic [3:0] f);
        logic [16:0] m;
        case (f)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] div_by_f(input logic [10:0] x, input logic [16:0] m);
        logic [27:0] p;
        p = 28'(x) * 28'(m);
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bzoom_ctrl.sv */
// tile sequencer: pixel counters, tile offsets and output coordinates
// depends on bzoom_pkg
`timescale 1ns / 1ps
`default_nettype none

module bzoom_ctrl #(
    parameter int CW = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [3:0]          i_f,
    input  wire logic [13:0]         i_w,
    input  wire logic [10:0]         i_h,
    input  wire bzoom_pkg::t_dp_stat i_stat,
    output bzoom_pkg::t_dp_cmd       o_cmd,
    output logic [CW-1:0]            o_col_addr
);
    import bzoom_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state               r_state;
    logic [CW-1:0]        r_col;
    logic [ROW_CNT_W-1:0] r_row;
    logic [3:0]           r_kr, r_kc, r_kc_first;
    logic [12:0]          r_rowbase, r_colbase;
    logic                 r_flast;

    logic        accept, row_end, frame_end, issue, last;
    logic [19:0] row_prod, col_prod;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign row_end   = (14'(r_col) + 14'd1) >= i_w;
    assign frame_end = row_end && ((11'(r_row) + 11'd1) >= i_h);
    assign issue     = (r_state == ST_RUN) && i_stat.advance;
    assign last      = (r_kr == i_f) && (r_kc == i_f);
    assign row_prod  = 20'(r_row) * 20'(i_f);
    assign col_prod  = 20'(r_col) * 20'(i_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_kr    <= '0;
            r_kc    <= '0;
            r_kc_first <= '0;
            r_rowbase  <= '0;
            r_colbase  <= '0;
            r_flast    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state    <= ST_RUN;
                        r_kr       <= (r_row == '0) ? i_f : 4'd1;
                        r_kc       <= (r_col == '0) ? i_f : 4'd1;
                        r_kc_first <= (r_col == '0) ? i_f : 4'd1;
                        r_rowbase  <= row_prod[12:0];
                        r_colbase  <= col_prod[12:0];
                        r_flast    <= frame_end;
                        if (row_end) begin
                            r_col <= '0;
                            r_row <= frame_end ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (last) begin
                            r_state <= ST_IDLE;
                        end else if (r_kc == i_f) begin
                            r_kc <= r_kc_first;
                            r_kr <= r_kr + 4'd1;
                        end else begin
                            r_kc <= r_kc + 4'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_col_addr = r_col;

    always_comb begin
        o_cmd.load       = accept;
        o_cmd.issue      = issue;
        o_cmd.kr         = r_kr;
        o_cmd.kc         = r_kc;
        o_cmd.row        = r_rowbase + 13'(r_kr) - 13'(i_f);
        o_cmd.col        = r_colbase + 13'(r_kc) - 13'(i_f);
        o_cmd.tile_last  = last;
        o_cmd.frame_last = last && r_flast;
    end

endmodule

`default_nettype wire

/* rtl/core/bzoom_dp.sv */
// corner registers, line store and four-stage interpolation pipeline
// depends on bzoom_pkg
`timescale 1ns / 1ps
`default_nettype none

module bzoom_dp #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bzoom_pkg::t_dp_cmd i_cmd,
    input  wire logic [CW-1:0]      i_col_addr,
    input  wire bzoom_pkg::t_pix_in i_pix,
    input  wire logic [3:0]         i_f,
    output bzoom_pkg::t_dp_stat     o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bzoom_pkg::t_pix_out     o_out_data
);
    import bzoom_pkg::*;

    logic [23:0] r_mem [MAX_WIDTH];
    logic [23:0] r_tr, r_tl, r_bl, r_br;

    // pipeline
    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic [3:0]  r_s1_kr, r_s2_kr;
    logic [12:0] r_s1_row, r_s1_col, r_s2_row, r_s2_col, r_s3_row, r_s3_col;
    logic [1:0]  r_s1_last, r_s2_last, r_s3_last;
    logic [10:0] r_s1_ta [3];
    logic [10:0] r_s1_tb [3];
    logic [10:0] r_s1_ba [3];
    logic [10:0] r_s1_bb [3];
    logic [7:0]  r_s2_top [3];
    logic [7:0]  r_s2_bot [3];
    logic [10:0] r_s3_a [3];
    logic [10:0] r_s3_b [3];
    t_pix_out    r_out;

    logic        adv;
    logic [16:0] m;
    logic [3:0]  fmkc, fmkr;
    logic [7:0]  vout [3];

    assign adv  = !r_out_valid || !i_out_stall;
    assign m    = recip(i_f);
    assign fmkc = i_f - i_cmd.kc;
    assign fmkr = i_f - r_s2_kr;

    // line store: read old entry and write the new pixel at the same column
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_col_addr] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr <= '0;
            r_tl <= '0;
            r_bl <= '0;
            r_br <= '0;
        end else if (i_cmd.load) begin
            r_tr <= r_mem[i_col_addr];
            r_tl <= r_tr;
            r_bl <= r_br;
            r_br <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_cmd.issue;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kr   <= i_cmd.kr;
            r_s1_row  <= i_cmd.row;
            r_s1_col  <= i_cmd.col;
            r_s1_last <= {i_cmd.tile_last, i_cmd.frame_last};
            r_s2_kr   <= r_s1_kr;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_last <= r_s1_last;
            r_s3_row  <= r_s2_row;
            r_s3_col  <= r_s2_col;
            r_s3_last <= r_s2_last;
            for (int ch = 0; ch < 3; ch++) begin
                // horizontal weights, a zero weight drops the missing left corners
                r_s1_ta[ch] <= (fmkc == '0) ? '0 : 11'(fmkc) * 11'(r_tl[16-8*ch +: 8]);
                r_s1_tb[ch] <= 11'(i_cmd.kc) * 11'(r_tr[16-8*ch +: 8]);
                r_s1_ba[ch] <= (fmkc == '0) ? '0 : 11'(fmkc) * 11'(r_bl[16-8*ch +: 8]);
                r_s1_bb[ch] <= 11'(i_cmd.kc) * 11'(r_br[16-8*ch +: 8]);
                // divide and sum
                r_s2_top[ch] <= div_by_f(r_s1_ta[ch], m) + div_by_f(r_s1_tb[ch], m);
                r_s2_bot[ch] <= div_by_f(r_s1_ba[ch], m) + div_by_f(r_s1_bb[ch], m);
                // vertical weights, a zero weight drops the missing top row
                r_s3_a[ch] <= (fmkr == '0) ? '0 : 11'(fmkr) * 11'(r_s2_top[ch]);
                r_s3_b[ch] <= 11'(r_s2_kr) * 11'(r_s2_bot[ch]);
            end
            r_out.out_row    <= r_s3_row;
            r_out.out_col    <= r_s3_col;
            r_out.out_red    <= vout[0];
            r_out.out_green  <= vout[1];
            r_out.out_blue   <= vout[2];
            r_out.tile_last  <= r_s3_last[1];
            r_out.frame_last <= r_s3_last[0];
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            vout[ch] = div_by_f(r_s3_a[ch], m) + div_by_f(r_s3_b[ch], m);
        end
    end

    assign o_stat.advance = adv;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

/* rtl/core/bilinear_integer_zoom_core.sv */
// Bilinear integer zoom core. Takes RGB pixels in raster order and, for each
// one, emits the f*f output tile whose bottom-right corner it is (only the
// last row or column of the tile on the first input row or column), one
// output pixel per cycle while the output is not stalled, each tagged with
// its output coordinates. An input pixel is loaded and then occupies the
// core until the tile sequencer has issued every output pixel of its tile;
// no new input is taken before that. Output pixels then pass
// a four-stage interpolation pipeline (horizontal weights, divide by f, vertical
// weights, divide by f) that drains while the next input is already loaded,
// so the pipeline latency adds only once. Division by f uses a reciprocal
// table. The previous input row sits in a MAX_WIDTH-entry line store; it is
// never cleared, so it holds valid data only for columns written in the
// current frame. Configuration registers must be written only while idle.
// depends on bzoom_pkg, bzoom_ctrl, bzoom_dp and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "bilinear_integer_zoom_core_macros.svh"

module bilinear_integer_zoom_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input pixel transaction
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire bzoom_pkg::t_pix_in                  i_in_data,
    // output pixel transaction
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output bzoom_pkg::t_pix_out                      o_out_data,
    // configuration write
    input  wire logic                                i_cfg_we,
    input  wire logic [bzoom_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bzoom_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bzoom_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [3:0]  r_cfg_f;
    logic [10:0] r_cfg_w, r_cfg_h;

    logic [3:0]  f_eff;
    logic [13:0] w_eff;
    logic [10:0] h_eff;

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [CW-1:0] col_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_f <= 4'd2;
            r_cfg_w <= 11'd1024;
            r_cfg_h <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZOOM:   r_cfg_f <= i_cfg_data[3:0];
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize values clamp to the limit
    always_comb begin
        if (r_cfg_f == '0) begin
            f_eff = 4'd1;
        end else if (32'(r_cfg_f) > MAX_FACTOR) begin
            f_eff = 4'(MAX_FACTOR);
        end else begin
            f_eff = r_cfg_f;
        end
        if (r_cfg_w == '0) begin
            w_eff = 14'd1;
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = 14'(MAX_WIDTH);
        end else begin
            w_eff = 14'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = 11'd1;
        end else if (32'(r_cfg_h) > HEIGHT_LIMIT) begin
            h_eff = 11'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    // sequencer: counters and tile walk
    bzoom_ctrl #(
        .CW(CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_f        (f_eff),
        .i_w        (w_eff),
        .i_h        (h_eff),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_col_addr (col_addr)
    );

    // line store and interpolation pipeline
    bzoom_dp #(
        .MAX_WIDTH(MAX_WIDTH),
        .CW       (CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_col_addr  (col_addr),
        .i_pix       (i_in_data),
        .i_f         (f_eff),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // a taken input keeps the core busy for at least its first output
    `BZ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "core accepted a pixel but did not go busy")
    // end of frame only ever closes a tile
    `BZ_ASSERT_NOW(a_frame_last_in_tile, i_clk, i_rst_n, o_out_valid && o_out_data.frame_last, o_out_data.tile_last, "frame_last without tile_last")
    // loading corners never coincides with issuing a tile pixel
    `BZ_ASSERT_NOW(a_load_not_issue, i_clk, i_rst_n, cmd.load, !cmd.issue, "load and issue in the same cycle")

endmodule

`default_nettype wire
